// ----- hw/rtl/rsas_pkg.sv -----
// Shared types and constants for the rotated sorted array search block.
`timescale 1ns / 1ps
`default_nettype none
package rsas_pkg;

  // Default store depth and fixed field widths
  localparam int DEPTH_DEFAULT = 1024;
  localparam int VALUE_W       = 32;
  localparam int POS_W         = 10;
  localparam int OUT_TDATA_W   = 16;

  // Operation codes carried in the input tuser
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Search sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_CHK,
    ST_P_MID,
    ST_P_NEXT,
    ST_P_LO,
    ST_P_DEC,
    ST_B_MID,
    ST_B_CMP,
    ST_DONE
  } state_t;

  // Search result handed from sequencer to output register
  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } result_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rsas_store.sv -----
// Element store: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rsas_store #(
  parameter int DEPTH = rsas_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [AW-1:0]                       wr_addr,
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] wr_data,
  input  wire logic                                rd_en,
  input  wire logic [AW-1:0]                       rd_addr,
  output logic signed [rsas_pkg::VALUE_W-1:0]      rd_data
);

  logic signed [rsas_pkg::VALUE_W-1:0] mem [DEPTH];

  // Write element
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read, with registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rsas_ctrl.sv -----
// Search sequencer: rotation point search and two bisections over the store.
`timescale 1ns / 1ps
`default_nettype none
module rsas_ctrl #(
  parameter int DEPTH = rsas_pkg::DEPTH_DEFAULT,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] target,
  input  wire logic [CW-1:0]                       count,
  output logic                                     rd_en,
  output logic [AW-1:0]                            rd_addr,
  input  wire logic signed [rsas_pkg::VALUE_W-1:0] rd_data,
  input  wire logic                                out_free,
  output logic                                     idle,
  output logic                                     done,
  output rsas_pkg::result_t                        result
);

  localparam int IW = CW + 1;
  localparam int PW = rsas_pkg::POS_W;

  rsas_pkg::state_t state, state_next;

  logic signed [IW-1:0]                lo, lo_next;
  logic signed [IW-1:0]                hi, hi_next;
  logic signed [IW-1:0]                mid, mid_next;
  logic signed [IW-1:0]                piv, piv_next;
  logic                                right, right_next;
  logic signed [rsas_pkg::VALUE_W-1:0] vm, vm_next;
  logic signed [rsas_pkg::VALUE_W-1:0] tgt;
  rsas_pkg::result_t                   res, res_next;

  logic signed [IW:0]   sum_c;
  logic signed [IW-1:0] mid_c;
  logic signed [IW-1:0] mid_p1;
  logic signed [IW-1:0] last_idx;

  // Midpoint of the current range; the sum is never negative where used
  assign sum_c    = {lo[IW-1], lo} + {hi[IW-1], hi};
  assign mid_c    = sum_c[IW:1];
  assign mid_p1   = mid + IW'(1);
  assign last_idx = $signed({1'b0, count}) - IW'(1);

  assign result = res;
  assign idle   = (state == rsas_pkg::ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rsas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
    piv   <= piv_next;
    right <= right_next;
    vm    <= vm_next;
    res   <= res_next;
    if (start) begin
      tgt <= target;
    end
  end

  // Next state, read requests and datapath updates
  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    piv_next   = piv;
    right_next = right;
    vm_next    = vm;
    res_next   = res;
    rd_en      = 1'b0;
    rd_addr    = mid_c[AW-1:0];
    done       = 1'b0;
    case (state)
      rsas_pkg::ST_IDLE: begin
        if (start) begin
          if (count == '0) begin
            res_next   = '0;
            state_next = rsas_pkg::ST_DONE;
          end else begin
            rd_en      = 1'b1;
            rd_addr    = '0;
            state_next = rsas_pkg::ST_RD_LAST;
          end
        end
      end
      rsas_pkg::ST_RD_LAST: begin
        // First element arrives; fetch the last
        vm_next    = rd_data;
        rd_en      = 1'b1;
        rd_addr    = last_idx[AW-1:0];
        state_next = rsas_pkg::ST_CHK;
      end
      rsas_pkg::ST_CHK: begin
        if (vm <= rd_data) begin
          // Not rotated: left part is empty
          piv_next   = '0;
          lo_next    = '0;
          hi_next    = -IW'(1);
          right_next = 1'b0;
          state_next = rsas_pkg::ST_B_MID;
        end else begin
          lo_next    = '0;
          hi_next    = last_idx;
          state_next = rsas_pkg::ST_P_MID;
        end
      end
      rsas_pkg::ST_P_MID: begin
        if (lo < hi) begin
          rd_en      = 1'b1;
          mid_next   = mid_c;
          state_next = rsas_pkg::ST_P_NEXT;
        end else begin
          piv_next   = lo;
          hi_next    = lo - IW'(1);
          lo_next    = '0;
          right_next = 1'b0;
          state_next = rsas_pkg::ST_B_MID;
        end
      end
      rsas_pkg::ST_P_NEXT: begin
        vm_next    = rd_data;
        rd_en      = 1'b1;
        rd_addr    = mid_p1[AW-1:0];
        state_next = rsas_pkg::ST_P_LO;
      end
      rsas_pkg::ST_P_LO: begin
        if (vm > rd_data) begin
          // Descent found: rotation point is mid + 1
          piv_next   = mid_p1;
          lo_next    = '0;
          hi_next    = mid;
          right_next = 1'b0;
          state_next = rsas_pkg::ST_B_MID;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = lo[AW-1:0];
          state_next = rsas_pkg::ST_P_DEC;
        end
      end
      rsas_pkg::ST_P_DEC: begin
        if (vm < rd_data) begin
          hi_next = mid;
        end else begin
          lo_next = mid_p1;
        end
        state_next = rsas_pkg::ST_P_MID;
      end
      rsas_pkg::ST_B_MID: begin
        if (lo <= hi) begin
          rd_en      = 1'b1;
          mid_next   = mid_c;
          state_next = rsas_pkg::ST_B_CMP;
        end else if (!right) begin
          // Left part exhausted: search from the rotation point up
          lo_next    = piv;
          hi_next    = last_idx;
          right_next = 1'b1;
        end else begin
          res_next   = '0;
          state_next = rsas_pkg::ST_DONE;
        end
      end
      rsas_pkg::ST_B_CMP: begin
        if (rd_data == tgt) begin
          res_next.found    = 1'b1;
          res_next.position = PW'(mid);
          state_next        = rsas_pkg::ST_DONE;
        end else begin
          if (rd_data < tgt) begin
            lo_next = mid_p1;
          end else begin
            hi_next = mid - IW'(1);
          end
          state_next = rsas_pkg::ST_B_MID;
        end
      end
      rsas_pkg::ST_DONE: begin
        // Hold the result until the output register is free
        done = 1'b1;
        if (out_free) begin
          state_next = rsas_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rsas_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rotated_sorted_array_search.sv -----
// A load item gives no result. A search runs R <= log2(n) rotation steps
// and B <= 2*(log2(n)+1) bisection probes, all through the single store read port.
// Throughput: one item at a time; a new item is taken once the previous search
// has handed its result to the output register, which may still be waiting.
// Reset clears count, fill pointer and control; store contents are kept.
`timescale 1ns / 1ps
`default_nettype none
module rotated_sorted_array_search #(
  parameter int DEPTH = rsas_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic [rsas_pkg::VALUE_W-1:0]          s_tdata,  // [31:0] value
  input  wire logic                                  s_tuser,  // [0] op
  input  wire logic                                  s_tlast,
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic [rsas_pkg::OUT_TDATA_W-1:0]           m_tdata,  // [9:0] position
  output logic                                       m_tuser   // [0] found
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] element_count;
  logic [CW-1:0] fill_pointer, fill_pointer_next;
  logic          in_acc, load_acc, search_acc;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic signed [rsas_pkg::VALUE_W-1:0] rd_data;
  logic          out_free;
  logic          idle;
  logic          done;
  rsas_pkg::result_t result;

  assign in_acc     = s_tvalid && s_tready;
  assign load_acc   = in_acc && (s_tuser == rsas_pkg::OP_LOAD);
  assign search_acc = in_acc && (s_tuser == rsas_pkg::OP_SEARCH);
  assign s_tready   = idle;
  assign out_free   = !m_tvalid || m_tready;

  // Drop elements beyond the store depth
  assign wr_en = load_acc && (fill_pointer < CW'(DEPTH));
  assign fill_pointer_next = wr_en ? fill_pointer + CW'(1) : fill_pointer;

  // Track fill pointer and completed load size
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_pointer  <= '0;
      element_count <= '0;
    end else if (load_acc) begin
      if (s_tlast) begin
        element_count <= fill_pointer_next;
        fill_pointer  <= '0;
      end else begin
        fill_pointer <= fill_pointer_next;
      end
    end
  end

  // Loads and searches never overlap, so store writes and reads cannot collide
  rsas_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (fill_pointer[AW-1:0]),
    .wr_data (s_tdata),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  rsas_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (search_acc),
    .target   (s_tdata),
    .count    (element_count),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .out_free (out_free),
    .idle     (idle),
    .done     (done),
    .result   (result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && out_free) begin
      m_tdata <= rsas_pkg::OUT_TDATA_W'(result.position);
      m_tuser <= result.found;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    element_count <= CW'(DEPTH))
    else $error("element count beyond depth");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_pointer <= CW'(DEPTH))
    else $error("fill pointer beyond depth");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !rd_en)
    else $error("store write during search read");

  a_notfound_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("not-found item carries nonzero position");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (done && out_free) |=> (m_tvalid && idle))
    else $error("finished search did not reach output register");
`endif

endmodule
`default_nettype wire

// ----- tb/sv/rotated_sorted_array_search_tb.sv -----
// Self-checking stream testbench for the rotated sorted array search block.
`timescale 1ns / 1ps
module rotated_sorted_array_search_tb;

  localparam int  HALF_PERIOD    = 10;
  localparam int  STORE_DEPTH    = rsas_pkg::DEPTH_DEFAULT;
  localparam int  VALUE_MAX      = 32'sh7fffffff;
  localparam int  VALUE_MIN      = 32'sh80000000;
  localparam int  HOLD_CYCLES    = 400;
  localparam int  RANDOM_ITEMS   = 320;
  localparam int  OVERFLOW_LOADS = STORE_DEPTH + 6;
  localparam int  TAIL_CYCLES    = 40;

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [rsas_pkg::VALUE_W-1:0]     s_tdata;
  logic                             s_tuser;
  logic                             s_tlast;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [rsas_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic                             m_tuser;

  bit calm        = 1'b0;
  int hold_asks   = 0;
  int hold_served = 0;
  int items_sent  = 0;

  // Mirror of the element store plus the queue of search answers still owed
  class search_board;
    int                store [STORE_DEPTH];
    int                count;
    int                fill;
    rsas_pkg::result_t awaited_results[$];
    int                mismatches;
    int                loads;
    int                searches;
    int                hits;

    function new();
      foreach (store[i]) store[i] = 0;
      count = 0;
      fill = 0;
      mismatches = 0;
      loads = 0;
      searches = 0;
      hits = 0;
    endfunction

    function int pending_count();
      return awaited_results.size();
    endfunction

    // Locate the first index of the ascending run
    function int rotation_of(int n);
      int lo, hi, mid;
      lo = 0;
      hi = n - 1;
      if (store[lo] <= store[hi]) return 0;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (store[mid] > store[mid + 1]) return mid + 1;
        if (store[mid] < store[lo]) hi = mid;
        else lo = mid + 1;
      end
      return lo;
    endfunction

    function int bisect_range(int lo, int hi, int target);
      int mid;
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (store[mid] == target) return mid;
        if (store[mid] < target) lo = mid + 1;
        else hi = mid - 1;
      end
      return -1;
    endfunction

    // Apply one accepted item; a search queues the answer it must produce
    function void note_item(logic op, int value, logic last);
      int                piv;
      int                idx;
      rsas_pkg::result_t res;
      if (op == rsas_pkg::OP_LOAD) begin
        loads++;
        // drop elements past the end of the store
        if (fill < STORE_DEPTH) begin
          store[fill] = value;
          fill++;
        end
        if (last) begin
          count = fill;
          fill = 0;
        end
        return;
      end
      searches++;
      idx = -1;
      if (count > 0) begin
        piv = rotation_of(count);
        idx = bisect_range(0, piv - 1, value);
        if (idx < 0) idx = bisect_range(piv, count - 1, value);
      end
      res.found    = (idx >= 0);
      res.position = (idx >= 0) ? rsas_pkg::POS_W'(idx) : '0;
      if (res.found) hits++;
      awaited_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      $display("%0t ns mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic found, logic [rsas_pkg::OUT_TDATA_W-1:0] data);
      rsas_pkg::result_t want;
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with none due: found=%0b position=%0d",
                                  found, data[rsas_pkg::POS_W-1:0]));
        return;
      end
      want = awaited_results.pop_front();
      if (found !== want.found)
        report_mismatch($sformatf("found %0b, want %0b", found, want.found));
      if (data[rsas_pkg::POS_W-1:0] !== want.position)
        report_mismatch($sformatf("position %0d, want %0d",
                                  data[rsas_pkg::POS_W-1:0], want.position));
      if (data[rsas_pkg::OUT_TDATA_W-1:rsas_pkg::POS_W] !== '0)
        report_mismatch($sformatf("tdata padding not zero: %h", data));
    endtask

    task close_out();
      while (awaited_results.size() != 0) begin
        report_mismatch("search answer never arrived");
        void'(awaited_results.pop_front());
      end
    endtask
  endclass

  search_board tracker;

  rotated_sorted_array_search DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial clk = 1'b0;
  always #(HALF_PERIOD) clk = ~clk;

  // Receiver: random stalls, none while calm, plus long hold-offs on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_served) begin
        hold_served++;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        m_tready <= calm || ($urandom_range(99, 0) >= 6);
      end
    end
  end

  // Check every result taken at an edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tuser, m_tdata);
  end

  // Offer one item, idling now and then, and hold it until taken
  task automatic push_item(input logic op, input int value, input logic last);
    while (!calm && $urandom_range(99, 0) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tracker.note_item(op, value, last);
    items_sent++;
  endtask

  task automatic push_search(input int target);
    push_item(rsas_pkg::OP_SEARCH, target, $urandom_range(1, 0) == 1);
  endtask

  // Stop offering and wait until every search has answered
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_count() != 0) @(posedge clk);
  endtask

  function automatic int pick_target(input int vals[$]);
    int pick;
    int k;
    pick = $urandom_range(99, 0);
    k = $urandom_range(vals.size() - 1, 0);
    if (pick < 60) return vals[k];
    if (pick < 75) return pick[0] ? vals[k] + 1 : vals[k] - 1;
    if (pick < 90) return int'($urandom);
    return pick[0] ? VALUE_MAX : VALUE_MIN;
  endfunction

  // Rotated ascending run longer than the store; the tail is dropped
  function automatic int overflow_value(int i);
    return ((i + 300) % OVERFLOW_LOADS) * 8 - 4000;
  endfunction

  // One load of a rotated sorted (or scrambled) array, then a few searches
  task automatic random_set();
    int     n, step_max, rot, split_at, pick, i;
    longint start_v, acc;
    bit     scrambled, split_load;
    int     sorted_v[$];
    int     vals[$];
    pick = $urandom_range(99, 0);
    if (pick < 70) n = $urandom_range(16, 1);
    else if (pick < 95) n = $urandom_range(64, 17);
    else n = $urandom_range(300, 65);
    case ($urandom_range(3, 0))
      0: begin
        step_max = 1;
      end
      1: begin
        step_max = 3;
      end
      2: begin
        step_max = 1000;
      end
      default: begin
        step_max = 1 << 22;
      end
    endcase
    pick = $urandom_range(9, 0);
    start_v = (pick == 0) ? longint'(VALUE_MIN) : longint'(int'($urandom));
    if (pick == 1 || start_v + longint'(step_max) * n > longint'(VALUE_MAX))
      start_v = longint'(VALUE_MAX) - longint'(step_max) * n;
    acc = start_v;
    for (i = 0; i < n; i++) begin
      sorted_v.push_back(int'(acc));
      acc += $urandom_range(step_max, 0);
    end
    scrambled = $urandom_range(99, 0) < 15;
    rot = $urandom_range(n - 1, 0);
    for (i = 0; i < n; i++)
      vals.push_back(scrambled ? int'($urandom) : sorted_v[(i + rot) % n]);
    // now and then a search lands in the middle of the load
    split_load = $urandom_range(99, 0) < 10;
    split_at = $urandom_range(n - 1, 0);
    for (i = 0; i < n; i++) begin
      if (split_load && i == split_at) push_search(pick_target(vals));
      push_item(rsas_pkg::OP_LOAD, vals[i], i == n - 1);
    end
    repeat ($urandom_range(6, 1)) push_search(pick_target(vals));
  endtask

  // Stimulus: directed cases, overflow load, then random sets
  initial begin
    int boot_vals[7];
    int probe_idx[10];
    int i, k, sets, random_start;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = rsas_pkg::OP_LOAD;
    s_tlast = 1'b0;
    tracker = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty store
    push_item(rsas_pkg::OP_SEARCH, 0, 1'b0);
    push_item(rsas_pkg::OP_SEARCH, VALUE_MIN, 1'b1);

    // rotated array holding both extremes
    boot_vals = '{5, 7, VALUE_MAX, VALUE_MIN, -1, 0, 3};
    for (i = 0; i < 7; i++) push_item(rsas_pkg::OP_LOAD, boot_vals[i], i == 6);
    push_item(rsas_pkg::OP_SEARCH, VALUE_MAX, 1'b0);
    push_item(rsas_pkg::OP_SEARCH, VALUE_MIN, 1'b0);
    push_item(rsas_pkg::OP_SEARCH, 5, 1'b0);
    push_item(rsas_pkg::OP_SEARCH, 3, 1'b1);
    push_item(rsas_pkg::OP_SEARCH, 0, 1'b0);
    push_item(rsas_pkg::OP_SEARCH, 4, 1'b0);
    push_item(rsas_pkg::OP_SEARCH, -2, 1'b0);

    // single element
    push_item(rsas_pkg::OP_LOAD, 42, 1'b1);
    push_item(rsas_pkg::OP_SEARCH, 42, 1'b0);
    push_item(rsas_pkg::OP_SEARCH, 41, 1'b0);

    // search while a new load has overwritten the first slot
    push_item(rsas_pkg::OP_LOAD, 100, 1'b0);
    push_item(rsas_pkg::OP_SEARCH, 100, 1'b0);
    push_item(rsas_pkg::OP_SEARCH, 42, 1'b0);
    push_item(rsas_pkg::OP_LOAD, 200, 1'b0);
    push_item(rsas_pkg::OP_LOAD, 300, 1'b1);
    push_item(rsas_pkg::OP_SEARCH, 300, 1'b0);

    // long receiver hold-off while searches keep coming, then drain
    hold_asks++;
    for (i = 0; i < 8; i++) push_search(100 * $urandom_range(4, 0));
    wait_drained();

    // overflow: more elements than the store holds
    for (i = 0; i < OVERFLOW_LOADS; i++)
      push_item(rsas_pkg::OP_LOAD, overflow_value(i), i == OVERFLOW_LOADS - 1);
    probe_idx = '{0, 1, 729, 730, 731, 1022, 1023, 1024, 1029, 512};
    for (i = 0; i < 10; i++) push_search(overflow_value(probe_idx[i]));
    for (i = 0; i < 8; i++) begin
      k = $urandom_range(OVERFLOW_LOADS - 1, 0);
      push_search(overflow_value(k) + ((i % 4 == 0) ? 4 : 0));
    end

    // random sets, with a quiet stretch, a hold-off and a drain pause
    sets = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      calm = (items_sent - random_start >= 100) && (items_sent - random_start < 250);
      if (sets == 2) hold_asks++;
      if (sets == 6) wait_drained();
      random_set();
      sets++;
    end
    calm = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    tracker.close_out();

    $display("Run covered %0d loads and %0d searches (%0d found, %0d not found),",
             tracker.loads, tracker.searches, tracker.hits,
             tracker.searches - tracker.hits);
    $display("including empty, single, partial and over-deep loads; %0d mismatches.",
             tracker.mismatches);
    if (tracker.mismatches == 0) begin
      $display("[rotated_sorted_array_search] OK");
    end else begin
      $display("[rotated_sorted_array_search] ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20_000_000;
    $display("[rotated_sorted_array_search] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rsas_pkg.sv
hw/rtl/rsas_store.sv
hw/rtl/rsas_ctrl.sv
hw/rtl/rotated_sorted_array_search.sv
tb/sv/rotated_sorted_array_search_tb.sv
